// ----- sv/vbdm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vbdm_pkg;

	// fixed field widths
	localparam int GS_W   = 5;
	localparam int RAD_W  = 4;
	localparam int CRD_W  = 4;
	localparam int ACT_W  = 2;
	localparam int MCNT_W = 12;
	localparam int TOT_W  = 13;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 5;

	// item actions
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MARK   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_GRID_SIZE   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_BAND_LAYERS = 3'd1;
	localparam logic [CIDX_W-1:0] REG_HALO_ENABLE = 3'd2;
	localparam logic [CIDX_W-1:0] REG_HALO_LAYERS = 3'd3;
	localparam logic [CIDX_W-1:0] REG_HALO_LOCAL  = 3'd4;

	localparam logic [MCNT_W-1:0] MCNT_MAX = 12'd4095;
	localparam logic [TOT_W-1:0]  TOT_MAX  = 13'd8191;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MARK,
		ST_RQ,
		ST_RD,
		ST_X_RD,
		ST_X_WR,
		ST_Y_RD,
		ST_Y_AC,
		ST_Y_WR,
		ST_Z_RD,
		ST_Z_AC,
		ST_Z_WR,
		ST_SHELL,
		ST_C_RD,
		ST_C_AC,
		ST_FOUT
	} st_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_CLEAR,
		DP_CNT_CLR,
		DP_CNT_UP,
		DP_MARK,
		DP_FIN_START,
		DP_XPASS,
		DP_ACC_Y,
		DP_ACC_Z,
		DP_YWR,
		DP_ZWR,
		DP_SHELL,
		DP_COUNT,
		DP_OUT_READ,
		DP_OUT_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic             acc_clr;
		logic [RAD_W-1:0] radius;
		logic             to_halo;
		logic             shell_full;
		logic             ingrid;
		logic [CRD_W-1:0] bit_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic present;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic [RAD_W-1:0] band_layers;
		logic             halo_enable;
		logic [RAD_W-1:0] halo_layers;
		logic             halo_local;
	} mode_cfg_t;

endpackage

`default_nettype wire

// ----- sv/vbdm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// input item channel
interface vbdm_item_if import vbdm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [CRD_W-1:0] coord_x;
	logic [CRD_W-1:0] coord_y;
	logic [CRD_W-1:0] coord_z;
	modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

// result word channel
interface vbdm_result_if import vbdm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              contact_flag;
	logic              exact_flag;
	logic              halo_flag;
	logic [MCNT_W-1:0] marked_cell_total;
	logic [TOT_W-1:0]  contact_node_total;
	logic [TOT_W-1:0]  exact_node_total;
	logic [TOT_W-1:0]  halo_node_total;
	modport source (output valid, contact_flag, exact_flag, halo_flag, marked_cell_total,
		contact_node_total, exact_node_total, halo_node_total, input ready);
	modport sink (input valid, contact_flag, exact_flag, halo_flag, marked_cell_total,
		contact_node_total, exact_node_total, halo_node_total, output ready);
endinterface

// configuration write channel
interface vbdm_cfg_if import vbdm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [CDAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/vbdm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vbdm_ctrl import vbdm_pkg::*; #(
	parameter int MAX_GRID = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	vbdm_item_if.sink                item,
	input  wire logic [$clog2(MAX_GRID):0] n,
	input  wire mode_cfg_t           mode,
	input  wire dp_stat_t            stat,
	output dp_cmd_t                  cmd,
	output logic [$clog2(MAX_GRID*MAX_GRID)-1:0] raddr,
	output logic [$clog2(MAX_GRID*MAX_GRID)-1:0] waddr
);

	localparam int NW    = $clog2(MAX_GRID) + 1;
	localparam int DEPTH = MAX_GRID * MAX_GRID;
	localparam int RW    = $clog2(DEPTH);

	st_t              state_q, state_d;
	logic [NW-1:0]    y_q, y_d, z_q, z_d, d_q, d_d;
	logic [1:0]       k_q, k_d;
	logic [RW-1:0]    sweep_q, sweep_d;
	logic             halo_q, halo_d, ingrid_q, ingrid_d;
	logic [CRD_W-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;

	logic [RAD_W-1:0] radius;
	logic [NW-1:0]    nm1, y_nx, z_nx;
	logic             last_y, last_row, mark_in, read_in;

	function automatic logic [RW-1:0] row_addr(input int a, input int b);
		return RW'(b * MAX_GRID + a);
	endfunction

	// window start, clipped at zero
	function automatic logic [NW-1:0] lo_of(input logic [NW-1:0] v, input logic [RAD_W-1:0] r);
		if (int'(v) > int'(r))
			return NW'(int'(v) - int'(r));
		return '0;
	endfunction

	// window end, clipped at the last node
	function automatic logic [NW-1:0] hi_of(input logic [NW-1:0] v, input logic [RAD_W-1:0] r,
		input logic [NW-1:0] last);
		if (int'(v) + int'(r) > int'(last))
			return last;
		return NW'(int'(v) + int'(r));
	endfunction

	// row walk helpers
	always_comb begin
		radius   = halo_q ? mode.halo_layers : mode.band_layers;
		nm1      = n - NW'(1);
		last_y   = (y_q == nm1);
		last_row = last_y && (z_q == nm1);
		y_nx     = last_y ? '0 : y_q + NW'(1);
		z_nx     = last_y ? z_q + NW'(1) : z_q;
		mark_in  = (int'(item.coord_x) < int'(n) - 1) && (int'(item.coord_y) < int'(n) - 1) &&
			(int'(item.coord_z) < int'(n) - 1);
		read_in  = (int'(item.coord_x) < int'(n)) && (int'(item.coord_y) < int'(n)) &&
			(int'(item.coord_z) < int'(n));
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
			y_q <= '0;
			z_q <= '0;
			d_q <= '0;
			k_q <= '0;
			halo_q <= 1'b0;
			ingrid_q <= 1'b0;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			y_q <= y_d;
			z_q <= z_d;
			d_q <= d_d;
			k_q <= k_d;
			halo_q <= halo_d;
			ingrid_q <= ingrid_d;
			cx_q <= cx_d;
			cy_q <= cy_d;
			cz_q <= cz_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		sweep_d = sweep_q;
		y_d = y_q;
		z_d = z_q;
		d_d = d_q;
		k_d = k_q;
		halo_d = halo_q;
		ingrid_d = ingrid_q;
		cx_d = cx_q;
		cy_d = cy_q;
		cz_d = cz_q;
		cmd = '0;
		cmd.op = DP_NONE;
		cmd.radius = radius;
		cmd.to_halo = halo_q;
		cmd.bit_idx = cx_q;
		cmd.ingrid = ingrid_q;
		raddr = '0;
		waddr = '0;
		item.ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = DP_CLEAR;
				waddr = sweep_q;
				sweep_d = sweep_q + RW'(1);
				if (sweep_q == RW'(DEPTH - 1)) begin
					sweep_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					cx_d = item.coord_x;
					cy_d = item.coord_y;
					cz_d = item.coord_z;
					unique case (item.action)
						ACT_CLEAR: begin
							cmd.op = DP_CNT_CLR;
							sweep_d = '0;
							state_d = ST_CLEAR;
						end
						ACT_MARK: begin
							if (mark_in) begin
								cmd.op = DP_CNT_UP;
								k_d = '0;
								state_d = ST_MARK;
							end
						end
						ACT_FINISH: begin
							cmd.op = DP_FIN_START;
							y_d = '0;
							z_d = '0;
							halo_d = 1'b0;
							state_d = ST_X_RD;
						end
						ACT_READ: begin
							ingrid_d = read_in;
							state_d = ST_RQ;
						end
					endcase
				end
			end
			// four corner rows, two nodes each
			ST_MARK: begin
				cmd.op = DP_MARK;
				waddr = row_addr(int'(cy_q) + int'(k_q[0]), int'(cz_q) + int'(k_q[1]));
				k_d = k_q + 2'd1;
				if (k_q == 2'd3)
					state_d = ST_IDLE;
			end
			ST_RQ: begin
				raddr = ingrid_q ? row_addr(int'(cy_q), int'(cz_q)) : '0;
				state_d = ST_RD;
			end
			ST_RD: begin
				raddr = ingrid_q ? row_addr(int'(cy_q), int'(cz_q)) : '0;
				if (stat.out_free) begin
					cmd.op = DP_OUT_READ;
					state_d = ST_IDLE;
				end
			end
			// x pass: contact row to pass a
			ST_X_RD: begin
				raddr = row_addr(int'(y_q), int'(z_q));
				state_d = ST_X_WR;
			end
			ST_X_WR: begin
				cmd.op = DP_XPASS;
				cmd.acc_clr = 1'b1;
				waddr = row_addr(int'(y_q), int'(z_q));
				if (last_row) begin
					y_d = '0;
					z_d = '0;
					d_d = '0;
					state_d = ST_Y_RD;
				end else begin
					y_d = y_nx;
					z_d = z_nx;
					state_d = ST_X_RD;
				end
			end
			// y pass: window of pass a rows into pass b
			ST_Y_RD: begin
				raddr = row_addr(int'(d_q), int'(z_q));
				state_d = ST_Y_AC;
			end
			ST_Y_AC: begin
				cmd.op = DP_ACC_Y;
				if (d_q == hi_of(y_q, radius, nm1))
					state_d = ST_Y_WR;
				else begin
					d_d = d_q + NW'(1);
					state_d = ST_Y_RD;
				end
			end
			ST_Y_WR: begin
				cmd.op = DP_YWR;
				cmd.acc_clr = 1'b1;
				waddr = row_addr(int'(y_q), int'(z_q));
				if (last_row) begin
					y_d = '0;
					z_d = '0;
					d_d = '0;
					state_d = ST_Z_RD;
				end else begin
					y_d = y_nx;
					z_d = z_nx;
					d_d = lo_of(y_nx, radius);
					state_d = ST_Y_RD;
				end
			end
			// z pass: window of pass b rows into exact and halo
			ST_Z_RD: begin
				raddr = row_addr(int'(y_q), int'(d_q));
				state_d = ST_Z_AC;
			end
			ST_Z_AC: begin
				cmd.op = DP_ACC_Z;
				if (d_q == hi_of(z_q, radius, nm1))
					state_d = ST_Z_WR;
				else begin
					d_d = d_q + NW'(1);
					state_d = ST_Z_RD;
				end
			end
			ST_Z_WR: begin
				cmd.op = DP_ZWR;
				cmd.acc_clr = 1'b1;
				waddr = row_addr(int'(y_q), int'(z_q));
				if (last_row) begin
					y_d = '0;
					z_d = '0;
					d_d = '0;
					if (!halo_q && mode.halo_enable && stat.present) begin
						if (mode.halo_local) begin
							halo_d = 1'b1;
							state_d = ST_X_RD;
						end else
							state_d = ST_SHELL;
					end else
						state_d = ST_C_RD;
				end else begin
					y_d = y_nx;
					z_d = z_nx;
					d_d = lo_of(z_nx, radius);
					state_d = ST_Z_RD;
				end
			end
			// boundary shell, one row a cycle
			ST_SHELL: begin
				cmd.op = DP_SHELL;
				cmd.radius = mode.halo_layers;
				cmd.shell_full = (int'(y_q) < int'(mode.halo_layers)) ||
					(int'(z_q) < int'(mode.halo_layers)) ||
					(int'(y_q) + int'(mode.halo_layers) >= int'(n)) ||
					(int'(z_q) + int'(mode.halo_layers) >= int'(n));
				waddr = row_addr(int'(y_q), int'(z_q));
				if (last_row) begin
					y_d = '0;
					z_d = '0;
					state_d = ST_C_RD;
				end else begin
					y_d = y_nx;
					z_d = z_nx;
				end
			end
			// count pass
			ST_C_RD: begin
				raddr = row_addr(int'(y_q), int'(z_q));
				state_d = ST_C_AC;
			end
			ST_C_AC: begin
				cmd.op = DP_COUNT;
				if (last_row)
					state_d = ST_FOUT;
				else begin
					y_d = y_nx;
					z_d = z_nx;
					state_d = ST_C_RD;
				end
			end
			ST_FOUT: begin
				if (stat.out_free) begin
					cmd.op = DP_OUT_FIN;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/vbdm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vbdm_dp import vbdm_pkg::*; #(
	parameter int MAX_GRID = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             cmd,
	input  wire logic [$clog2(MAX_GRID*MAX_GRID)-1:0] raddr,
	input  wire logic [$clog2(MAX_GRID*MAX_GRID)-1:0] waddr,
	input  wire logic [$clog2(MAX_GRID):0] n,
	output dp_stat_t                 stat,
	vbdm_result_if.source            result
);

	localparam int W     = MAX_GRID;
	localparam int DEPTH = MAX_GRID * MAX_GRID;
	localparam int TW    = $clog2(MAX_GRID * MAX_GRID * MAX_GRID + 1);
	localparam int PW    = $clog2(W + 1);

	// row memories, one word per x row
	logic [W-1:0] ct_mem [DEPTH];
	logic [W-1:0] ex_mem [DEPTH];
	logic [W-1:0] hl_mem [DEPTH];
	logic [W-1:0] pa_mem [DEPTH];
	logic [W-1:0] pb_mem [DEPTH];
	logic [W-1:0] ct_rd_q, ex_rd_q, hl_rd_q, pa_rd_q, pb_rd_q;

	logic         ct_we, ex_we, hl_we, pa_we, pb_we;
	logic [W-1:0] ct_mask, ex_mask, hl_mask;
	logic [W-1:0] ct_data, pa_data;
	logic [W-1:0] nmask, sel, shell_mask, acc_q;

	logic              present_q, out_valid_q;
	logic [MCNT_W-1:0] mcnt_q;
	logic [TW-1:0]     ctot_q, etot_q, htot_q;

	logic              contact_q, exact_q, halo_q;
	logic [MCNT_W-1:0] mtot_q;
	logic [TOT_W-1:0]  ctot_out_q, etot_out_q, htot_out_q;

	function automatic logic [W-1:0] onehot(input int idx);
		logic [W-1:0] v;
		for (int i = 0; i < W; i++)
			v[i] = (i == idx);
		return v;
	endfunction

	// clipped binary dilation along x
	function automatic logic [W-1:0] xdil(input logic [W-1:0] src, input logic [RAD_W-1:0] r);
		logic [W-1:0] v;
		v = src;
		for (int k = 1; k < W; k++)
			if (k <= int'(r))
				v = v | (src << k) | (src >> k);
		return v;
	endfunction

	function automatic logic [PW-1:0] popcount(input logic [W-1:0] v);
		logic [PW-1:0] c;
		c = '0;
		for (int i = 0; i < W; i++)
			c = c + PW'(v[i]);
		return c;
	endfunction

	function automatic logic [TOT_W-1:0] sat(input logic [TW-1:0] v);
		if (int'(v) > int'(TOT_MAX))
			return TOT_MAX;
		return TOT_W'(v);
	endfunction

	// grid masks along x
	always_comb begin
		for (int i = 0; i < W; i++) begin
			nmask[i] = (i < int'(n));
			shell_mask[i] = cmd.shell_full ||
				(i < int'(cmd.radius)) || (i + int'(cmd.radius) >= int'(n));
		end
		shell_mask = shell_mask & nmask;
		sel = onehot(int'(cmd.bit_idx));
	end

	// write ports
	always_comb begin
		ct_we = 1'b0;
		ex_we = 1'b0;
		hl_we = 1'b0;
		pa_we = 1'b0;
		pb_we = 1'b0;
		ct_mask = '0;
		ex_mask = '0;
		hl_mask = '0;
		ct_data = '0;
		pa_data = xdil(ct_rd_q & nmask, cmd.radius) & nmask;
		unique case (cmd.op)
			DP_CLEAR: begin
				ct_we = 1'b1;
				ex_we = 1'b1;
				hl_we = 1'b1;
				ct_mask = '1;
				ex_mask = '1;
				hl_mask = '1;
			end
			DP_MARK: begin
				ct_we = 1'b1;
				ct_mask = sel | onehot(int'(cmd.bit_idx) + 1);
				ct_data = '1;
			end
			DP_XPASS: pa_we = 1'b1;
			DP_YWR: pb_we = 1'b1;
			DP_ZWR: begin
				if (cmd.radius != '0) begin
					ex_we = 1'b1;
					ex_mask = acc_q & nmask;
					hl_we = cmd.to_halo;
					hl_mask = acc_q & nmask;
				end
			end
			DP_SHELL: begin
				ex_we = 1'b1;
				hl_we = 1'b1;
				ex_mask = shell_mask;
				hl_mask = shell_mask;
			end
			default: ;
		endcase
	end

	// contact memory, bit-masked write
	always_ff @(posedge clk) begin
		if (ct_we)
			for (int i = 0; i < W; i++)
				if (ct_mask[i])
					ct_mem[waddr][i] <= ct_data[i];
		ct_rd_q <= ct_mem[raddr];
	end

	// exact memory, set or clear under mask
	always_ff @(posedge clk) begin
		if (ex_we)
			for (int i = 0; i < W; i++)
				if (ex_mask[i])
					ex_mem[waddr][i] <= (cmd.op != DP_CLEAR);
		ex_rd_q <= ex_mem[raddr];
	end

	// halo memory
	always_ff @(posedge clk) begin
		if (hl_we)
			for (int i = 0; i < W; i++)
				if (hl_mask[i])
					hl_mem[waddr][i] <= (cmd.op != DP_CLEAR);
		hl_rd_q <= hl_mem[raddr];
	end

	// pass buffers
	always_ff @(posedge clk) begin
		if (pa_we)
			pa_mem[waddr] <= pa_data;
		pa_rd_q <= pa_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (pb_we)
			pb_mem[waddr] <= acc_q;
		pb_rd_q <= pb_mem[raddr];
	end

	// counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
			present_q <= 1'b0;
			ctot_q <= '0;
			etot_q <= '0;
			htot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == DP_OUT_READ || cmd.op == DP_OUT_FIN)
				out_valid_q <= 1'b1;
			else if (out_valid_q && result.ready)
				out_valid_q <= 1'b0;
			unique case (cmd.op)
				DP_CNT_CLR: mcnt_q <= '0;
				DP_CNT_UP: begin
					if (mcnt_q != MCNT_MAX)
						mcnt_q <= mcnt_q + MCNT_W'(1);
				end
				DP_FIN_START: begin
					present_q <= 1'b0;
					ctot_q <= '0;
					etot_q <= '0;
					htot_q <= '0;
				end
				DP_XPASS: present_q <= present_q | (|(ct_rd_q & nmask));
				DP_COUNT: begin
					ctot_q <= ctot_q + TW'(popcount(ct_rd_q & nmask));
					etot_q <= etot_q + TW'(popcount(ex_rd_q & nmask));
					htot_q <= htot_q + TW'(popcount(hl_rd_q & nmask));
				end
				default: ;
			endcase
		end
	end

	// window accumulator and result payload
	always_ff @(posedge clk) begin
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (cmd.op == DP_ACC_Y)
			acc_q <= acc_q | pa_rd_q;
		else if (cmd.op == DP_ACC_Z)
			acc_q <= acc_q | pb_rd_q;
		if (cmd.op == DP_OUT_READ) begin
			contact_q <= cmd.ingrid && (|(ct_rd_q & sel));
			exact_q <= cmd.ingrid && (|(ex_rd_q & sel));
			halo_q <= cmd.ingrid && (|(hl_rd_q & sel));
			mtot_q <= '0;
			ctot_out_q <= '0;
			etot_out_q <= '0;
			htot_out_q <= '0;
		end else if (cmd.op == DP_OUT_FIN) begin
			contact_q <= 1'b0;
			exact_q <= 1'b0;
			halo_q <= 1'b0;
			mtot_q <= mcnt_q;
			ctot_out_q <= sat(ctot_q);
			etot_out_q <= sat(etot_q);
			htot_out_q <= sat(htot_q);
		end
	end

	assign stat.present = present_q;
	assign stat.out_free = !out_valid_q || result.ready;

	assign result.valid = out_valid_q;
	assign result.contact_flag = contact_q;
	assign result.exact_flag = exact_q;
	assign result.halo_flag = halo_q;
	assign result.marked_cell_total = mtot_q;
	assign result.contact_node_total = ctot_out_q;
	assign result.exact_node_total = etot_out_q;
	assign result.halo_node_total = htot_out_q;

endmodule

`default_nettype wire

// ----- sv/voxel_band_dilation_marker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | payload
// item    | in  | action, coord_x, coord_y, coord_z
// result  | out | three node flags, four totals
// cfg     | in  | index, data (register write)
//
// read: a row lookup, then the result word; mark: 4 row writes for a cell inside the grid.
// clear: row clearing of all MAX_GRID^2 rows through the three flag memories.
// finish: per dilation (band, then a local halo) an x pass, and for y and z each a pass
// of row writes with a window of row reads each; a shell pass for a non-local halo; a counting pass; issue.
// after reset the same clearing pass runs before the first item is taken.
// a waiting result word stalls only the final issue step of the next read or finish.

module voxel_band_dilation_marker import vbdm_pkg::*; #(
	parameter int MAX_GRID = 16
) (
	input wire logic      clk,
	input wire logic      arst_n,
	vbdm_item_if.sink     item,
	vbdm_result_if.source result,
	vbdm_cfg_if.sink      cfg
);

	localparam int NW = $clog2(MAX_GRID) + 1;
	localparam int RW = $clog2(MAX_GRID * MAX_GRID);

	logic [GS_W-1:0]  grid_size_q;
	logic [RAD_W-1:0] band_layers_q, halo_layers_q;
	logic             halo_enable_q, halo_local_q;
	logic [NW-1:0]    n;
	mode_cfg_t        mode;
	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [RW-1:0]    raddr, waddr;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GS_W'(16);
			band_layers_q <= RAD_W'(1);
			halo_enable_q <= 1'b0;
			halo_layers_q <= RAD_W'(1);
			halo_local_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GRID_SIZE: grid_size_q <= cfg.data[GS_W-1:0];
				REG_BAND_LAYERS: band_layers_q <= cfg.data[RAD_W-1:0];
				REG_HALO_ENABLE: halo_enable_q <= cfg.data[0];
				REG_HALO_LAYERS: halo_layers_q <= cfg.data[RAD_W-1:0];
				REG_HALO_LOCAL: halo_local_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// active grid size, clamped
	always_comb begin
		if (grid_size_q < GS_W'(2))
			n = NW'(2);
		else if (int'(grid_size_q) > MAX_GRID)
			n = NW'(MAX_GRID);
		else
			n = NW'(grid_size_q);
		mode.band_layers = band_layers_q;
		mode.halo_enable = halo_enable_q;
		mode.halo_layers = halo_layers_q;
		mode.halo_local = halo_local_q;
	end

	vbdm_ctrl #(.MAX_GRID(MAX_GRID)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.n      (n),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.raddr  (raddr),
		.waddr  (waddr)
	);

	vbdm_dp #(.MAX_GRID(MAX_GRID)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.raddr  (raddr),
		.waddr  (waddr),
		.n      (n),
		.stat   (stat),
		.result (result)
	);

endmodule

`default_nettype wire
